[rtl/dmhq_pkg.sv]
// dmhq_pkg: shared types, constants and index helpers for the ternary max-heap queue
// no dependencies; imported by every module of the block except dmhq_ram
`default_nettype none

package dmhq_pkg;

	// heap geometry
	localparam int CAPACITY = 64;
	localparam int ARITY    = 3;
	localparam int KEY_W    = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CHILD_W  = $clog2(ARITY * CAPACITY + 1);
	localparam int J_W      = $clog2(ARITY);
	localparam int OP_W     = 2;
	localparam int STAT_W   = 3;

	// reciprocal of the arity, rounded up, exact for every slot index
	localparam int DIV_SH  = IDX_W + 4;
	localparam int DIV_MUL = ((1 << DIV_SH) + ARITY - 1) / ARITY;
	localparam int PROD_W  = IDX_W + DIV_SH;

	// stream packing, rounded up to whole bytes
	localparam int S_DATA_W = ((KEY_W + IDX_W + 7) / 8) * 8;
	localparam int S_USER_W = OP_W;
	localparam int M_DATA_W = ((STAT_W + 2 * KEY_W + CNT_W + 7) / 8) * 8;

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic [CHILD_W-1:0]      child_t;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT   = 2'd0,
		OP_EXTRACT  = 2'd1,
		OP_INCREASE = 2'd2,
		OP_NOP      = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_UNDERFLOW = 3'd1,
		ST_OVERFLOW  = 3'd2,
		ST_SMALLER   = 3'd3,
		ST_BADINDEX  = 3'd4
	} status_t;

	typedef struct packed {
		op_t  op;
		key_t key;
		idx_t slot;
	} cmd_t;

	typedef struct packed {
		status_t status;
		key_t    extracted;
		key_t    top;
		cnt_t    count;
	} result_t;

	// parent position of a non-root slot, (p - 1) / ARITY by reciprocal multiply
	function automatic idx_t parent_of(input idx_t p);
		idx_t              pm1;
		logic [PROD_W-1:0] prod;
		pm1  = p - 1'b1;
		prod = PROD_W'(pm1) * PROD_W'(DIV_MUL);
		return prod[DIV_SH +: IDX_W];
	endfunction

	// position of the first child of a slot
	function automatic child_t first_child(input idx_t p);
		return CHILD_W'(ARITY * int'(p) + 1);
	endfunction

endpackage

`default_nettype wire

[rtl/dmhq_ram.sv]
// dmhq_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module dmhq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/dmhq_engine.sv]
// dmhq_engine: command sequencer that sifts keys through the heap ram
// depends on dmhq_pkg and dmhq_ram
`default_nettype none

module dmhq_engine (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_valid,
	output logic                  cmd_ready,
	input  wire dmhq_pkg::cmd_t   cmd,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output dmhq_pkg::result_t     res
);
	import dmhq_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_EX_LD  = 8'b0000_0010,
		S_IN_CMP = 8'b0000_0100,
		S_UP_CMP = 8'b0000_1000,
		S_PUT    = 8'b0001_0000,
		S_DN_ISS = 8'b0010_0000,
		S_DN_CMP = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t          state_q, state_d;
	cnt_t            cnt_q, cnt_d;
	key_t            root_q, root_d;
	key_t            key_q, key_d;
	idx_t            pos_q, pos_d;
	idx_t            best_idx_q, best_idx_d;
	key_t            best_val_q, best_val_d;
	child_t          child_q, child_d;
	logic [J_W-1:0]  j_q, j_d;
	status_t         status_q, status_d;
	key_t            taken_q, taken_d;

	logic            we;
	idx_t            waddr, raddr;
	logic [KEY_W-1:0] wdata, rdata;
	key_t            rd;
	idx_t            par;
	child_t          fc, nc;
	logic            upd;
	idx_t            bi;
	key_t            bv;

	dmhq_ram #(
		.WIDTH (KEY_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd        = $signed(rdata);
	assign par       = parent_of(pos_q);
	assign fc        = first_child(pos_q);
	assign nc        = child_q + 1'b1;
	assign upd       = best_val_q < rd;
	assign bi        = upd ? child_q[IDX_W-1:0] : best_idx_q;
	assign bv        = upd ? rd : best_val_q;
	assign cmd_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	assign res.status    = status_q;
	assign res.extracted = taken_q;
	assign res.top       = (cnt_q != '0) ? root_q : '0;
	assign res.count     = cnt_q;

	// sequencer: one ram read and one ram write per cycle at most
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		key_d      = key_q;
		pos_d      = pos_q;
		best_idx_d = best_idx_q;
		best_val_d = best_val_q;
		child_d    = child_q;
		j_d        = j_q;
		status_d   = status_q;
		taken_d    = taken_q;
		we         = 1'b0;
		waddr      = pos_q;
		wdata      = key_q;
		raddr      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					status_d = ST_OK;
					taken_d  = '0;
					state_d  = S_DONE;
					unique case (cmd.op)
						OP_INSERT: begin
							if (cnt_q == CNT_W'(CAPACITY)) begin
								status_d = ST_OVERFLOW;
							end else begin
								key_d = cmd.key;
								pos_d = cnt_q[IDX_W-1:0];
								cnt_d = cnt_q + 1'b1;
								raddr = parent_of(cnt_q[IDX_W-1:0]);
								state_d = (cnt_q == '0) ? S_PUT : S_UP_CMP;
							end
						end
						OP_EXTRACT: begin
							if (cnt_q == '0) begin
								status_d = ST_UNDERFLOW;
							end else begin
								taken_d = root_q;
								cnt_d   = cnt_q - 1'b1;
								pos_d   = '0;
								raddr   = cnt_d[IDX_W-1:0];
								if (cnt_q != CNT_W'(1)) begin
									state_d = S_EX_LD;
								end
							end
						end
						OP_INCREASE: begin
							if (CNT_W'(cmd.slot) >= cnt_q) begin
								status_d = ST_BADINDEX;
							end else begin
								key_d   = cmd.key;
								pos_d   = cmd.slot;
								raddr   = cmd.slot;
								state_d = S_IN_CMP;
							end
						end
						OP_NOP: begin
							status_d = ST_OK;
						end
						default: begin
							status_d = ST_OK;
						end
					endcase
				end
			end
			// current key at the slot is in rd
			S_IN_CMP: begin
				if (key_q < rd) begin
					status_d = ST_SMALLER;
					state_d  = S_DONE;
				end else if (pos_q == '0) begin
					state_d = S_PUT;
				end else begin
					raddr   = par;
					state_d = S_UP_CMP;
				end
			end
			// parent key is in rd: pull it down or settle the key
			S_UP_CMP: begin
				we = 1'b1;
				if (rd < key_q) begin
					wdata = rd;
					pos_d = par;
					raddr = parent_of(par);
					state_d = (par == '0) ? S_PUT : S_UP_CMP;
				end else begin
					state_d = S_DONE;
				end
			end
			S_PUT: begin
				we      = 1'b1;
				state_d = S_DONE;
			end
			// last key is in rd, it goes down from the root
			S_EX_LD: begin
				key_d   = rd;
				state_d = S_DN_ISS;
			end
			S_DN_ISS: begin
				if (fc >= CHILD_W'(cnt_q)) begin
					we      = 1'b1;
					state_d = S_DONE;
				end else begin
					raddr      = fc[IDX_W-1:0];
					child_d    = fc;
					best_idx_d = pos_q;
					best_val_d = key_q;
					j_d        = '0;
					state_d    = S_DN_CMP;
				end
			end
			// one child in rd per cycle, first strictly largest wins
			S_DN_CMP: begin
				best_idx_d = bi;
				best_val_d = bv;
				if (j_q != J_W'(ARITY - 1) && nc < CHILD_W'(cnt_q)) begin
					raddr   = nc[IDX_W-1:0];
					child_d = nc;
					j_d     = j_q + 1'b1;
				end else if (bi == pos_q) begin
					we      = 1'b1;
					state_d = S_DONE;
				end else begin
					we      = 1'b1;
					wdata   = bv;
					pos_d   = bi;
					state_d = S_DN_ISS;
				end
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// root shadow follows every write to slot zero
	assign root_d = (we && waddr == '0) ? $signed(wdata) : root_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		root_q     <= root_d;
		key_q      <= key_d;
		pos_q      <= pos_d;
		best_idx_q <= best_idx_d;
		best_val_q <= best_val_d;
		child_q    <= child_d;
		j_q        <= j_d;
		status_q   <= status_d;
		taken_q    <= taken_d;
	end

endmodule

`default_nettype wire

[rtl/dary_max_heap_queue_top.sv]
// dary_max_heap_queue_top: stream wrapper around the heap engine with a result register
// depends on dmhq_pkg and dmhq_engine
//
// Ternary max-heap priority queue of up to 64 signed 32-bit keys.
// Slave channel: one command per beat, s_tuser carries the opcode (insert,
// extract maximum, increase key), s_tdata the key and the slot index.
// Master channel: one result beat per command with status, extracted key,
// root key and count.
// A command is taken only when the engine is idle; commands that fail or end
// at once go straight to the result. Otherwise insert/increase read one parent
// per heap level (plus the slot itself on increase), and extract has an issue
// step and one read per child of the single-read-port key ram at each level.
// Results sit in an output register: the engine may take and work one
// further command while a result waits, and then holds its result until
// the register frees up. A stalled receiver thus stalls the slave side
// after one command.
// Reset empties the heap (count zero) and clears both valids; the key ram
// itself is not cleared, only keys in slots below the count are ever used.
`default_nettype none

module dary_max_heap_queue_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// [31:0] new_key, [37:32] slot_index, [39:38] zero
	input  wire logic [dmhq_pkg::S_DATA_W-1:0] s_tdata,
	// [1:0] opcode
	input  wire logic [dmhq_pkg::S_USER_W-1:0] s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// [2:0] status, [34:3] extracted_key, [66:35] top_key,
	// [73:67] entry_count, [79:74] zero
	output logic      [dmhq_pkg::M_DATA_W-1:0] m_tdata
);
	import dmhq_pkg::*;

	cmd_t    cmd;
	result_t res;
	logic    res_valid, res_ready;
	result_t out_q;
	logic    out_valid_q;

	// unpack the command beat
	assign cmd.op   = op_t'(s_tuser[OP_W-1:0]);
	assign cmd.key  = $signed(s_tdata[KEY_W-1:0]);
	assign cmd.slot = s_tdata[KEY_W +: IDX_W];

	dmhq_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (s_tvalid),
		.cmd_ready (s_tready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || m_tready;

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	// pack the result beat
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(M_DATA_W - STAT_W - 2 * KEY_W - CNT_W)'(0),
		out_q.count, out_q.top, out_q.extracted, out_q.status};

endmodule

`default_nettype wire

[rtl/dmhq_checker.sv]
// dmhq_checker: port-level assertions for the heap queue, bound to the top level
// depends on dmhq_pkg and dary_max_heap_queue_top
`default_nettype none

module dmhq_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic [dmhq_pkg::S_DATA_W-1:0] s_tdata,
	input wire logic [dmhq_pkg::S_USER_W-1:0] s_tuser,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [dmhq_pkg::M_DATA_W-1:0] m_tdata
);
	import dmhq_pkg::*;

	logic [STAT_W-1:0] st;
	logic [KEY_W-1:0]  ext, top;
	logic [CNT_W-1:0]  cnt;

	assign st  = m_tdata[STAT_W-1:0];
	assign ext = m_tdata[STAT_W +: KEY_W];
	assign top = m_tdata[STAT_W + KEY_W +: KEY_W];
	assign cnt = m_tdata[STAT_W + 2 * KEY_W +: CNT_W];

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// count never exceeds capacity
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> cnt <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	// empty heap reports a zero root
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && cnt == '0 |-> top == '0)
		else $error("nonzero root on empty heap");

	// only a successful command may carry an extracted key
	a_ext: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st != ST_OK |-> ext == '0)
		else $error("extracted key on failed command");

endmodule

bind dary_max_heap_queue_top dmhq_checker u_dmhq_checker (.*);

`default_nettype wire

[test/dary_max_heap_queue_checker.sv]
`timescale 1ns / 100ps
// dary_max_heap_queue_checker: watches both stream channels of the heap queue,
// predicts each result beat from its own ternary heap and compares them field by field
// depends on dmhq_pkg for the opcode, status and result types

module dary_max_heap_queue_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	input  wire logic                          s_tready,
	// [31:0] new_key, [37:32] slot_index, [39:38] zero
	input  wire logic [dmhq_pkg::S_DATA_W-1:0] s_tdata,
	// [1:0] opcode
	input  wire logic [dmhq_pkg::S_USER_W-1:0] s_tuser,
	input  wire logic                          m_tvalid,
	input  wire logic                          m_tready,
	// [2:0] status, [34:3] extracted_key, [66:35] top_key, [73:67] entry_count
	input  wire logic [dmhq_pkg::M_DATA_W-1:0] m_tdata,
	output int                                 mismatch_count,
	output int                                 pending_results,
	output int                                 results_seen,
	output logic [4:0]                         status_seen
);
	import dmhq_pkg::*;

	localparam int REPORT_LIMIT = 10;

	// shadow heap, root at slot 0
	key_t        heap_keys [CAPACITY];
	int unsigned shadow_count;
	result_t     expected_results [$];

	initial begin
		mismatch_count  = 0;
		pending_results = 0;
		results_seen    = 0;
		status_seen     = '0;
		shadow_count    = 0;
	end

	function automatic void swap_slots(input int unsigned a, input int unsigned b);
		key_t t;
		t            = heap_keys[a];
		heap_keys[a] = heap_keys[b];
		heap_keys[b] = t;
	endfunction

	// move a key toward the root while it beats its parent strictly
	function automatic void heap_raise(input int unsigned pos);
		int unsigned up;
		while (pos > 0) begin
			up = (pos - 1) / ARITY;
			if (!(heap_keys[up] < heap_keys[pos]))
				break;
			swap_slots(pos, up);
			pos = up;
		end
	endfunction

	// move a key down, swapping with the first strictly largest child
	function automatic void heap_lower(input int unsigned pos);
		int unsigned best;
		int unsigned c;
		forever begin
			best = pos;
			for (int j = 0; j < ARITY; j++) begin
				c = pos * ARITY + j + 1;
				if (c < shadow_count && heap_keys[best] < heap_keys[c])
					best = c;
			end
			if (best == pos)
				break;
			swap_slots(pos, best);
			pos = best;
		end
	endfunction

	// apply one command to the shadow heap and return the result it must produce
	function automatic result_t heap_apply(input op_t op, input key_t key, input idx_t slot);
		result_t r;
		r.status    = ST_OK;
		r.extracted = '0;
		case (op)
			OP_INSERT: begin
				if (shadow_count >= CAPACITY) begin
					r.status = ST_OVERFLOW;
				end else begin
					heap_keys[shadow_count] = key;
					shadow_count++;
					heap_raise(shadow_count - 1);
				end
			end
			OP_EXTRACT: begin
				if (shadow_count == 0) begin
					r.status = ST_UNDERFLOW;
				end else begin
					r.extracted  = heap_keys[0];
					shadow_count--;
					heap_keys[0] = heap_keys[shadow_count];
					heap_lower(0);
				end
			end
			OP_INCREASE: begin
				if (slot >= shadow_count) begin
					r.status = ST_BADINDEX;
				end else if (key < heap_keys[slot]) begin
					r.status = ST_SMALLER;
				end else begin
					heap_keys[slot] = key;
					heap_raise(slot);
				end
			end
			default: ;
		endcase
		r.top   = (shadow_count > 0) ? heap_keys[0] : key_t'(0);
		r.count = cnt_t'(shadow_count);
		return r;
	endfunction

	function automatic void report_field(input string field, input longint want,
			input longint got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%t result %0d: %s expected %0d, got %0d", $realtime, results_seen,
				field, want, got);
	endfunction

	// compare result beats against the oldest prediction, then queue a new one
	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		result_t got;
		if (!arst_n) begin
			shadow_count = 0;
			expected_results.delete();
			pending_results <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.status    = status_t'(m_tdata[STAT_W-1:0]);
				got.extracted = m_tdata[STAT_W +: KEY_W];
				got.top       = m_tdata[STAT_W+KEY_W +: KEY_W];
				got.count     = m_tdata[STAT_W+2*KEY_W +: CNT_W];
				results_seen++;
				if (got.status <= ST_BADINDEX)
					status_seen[got.status] = 1'b1;
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("%t result beat %0d with nothing expected", $realtime,
							results_seen);
				end else begin
					want = expected_results.pop_front();
					if (got.status != want.status)
						report_field("status", want.status, got.status);
					if (got.extracted != want.extracted)
						report_field("extracted_key", want.extracted, got.extracted);
					if (got.top != want.top)
						report_field("top_key", want.top, got.top);
					if (got.count != want.count)
						report_field("entry_count", want.count, got.count);
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(heap_apply(op_t'(s_tuser),
					key_t'(s_tdata[KEY_W-1:0]), idx_t'(s_tdata[KEY_W +: IDX_W])));
			pending_results <= expected_results.size();
		end
	end

endmodule

[test/tb_dary_max_heap_queue_top.sv]
`timescale 1ns / 100ps
// tb_dary_max_heap_queue_top: command stimulus, result back-pressure and verdict
// for the ternary max-heap queue; depends on dmhq_pkg, the block and the checker

module tb_dary_max_heap_queue_top;
	import dmhq_pkg::*;

	localparam int   CLK_HALF      = 5;
	localparam int   RESET_CYCLES  = 9;
	localparam int   RANDOM_ITEMS  = 900;
	localparam int   IDLE_PCT      = 34;
	localparam int   STEADY_FROM   = 250;
	localparam int   STEADY_TO     = 400;
	localparam int   PHASE_LEN     = 150;
	localparam int   HOLD_AT       = 600;
	localparam int   HOLD_CYCLES   = 400;
	localparam int   DRAIN_CYCLES  = 40;
	localparam int   WATCHDOG_MAX  = 5000;
	localparam key_t KEY_MAX       = 32'sh7fff_ffff;
	localparam key_t KEY_MIN       = 32'sh8000_0000;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;
	logic [S_USER_W-1:0] s_tuser  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	int         mismatch_count;
	int         pending_results;
	int         results_seen;
	logic [4:0] status_seen;

	// stimulus bookkeeping
	int          sent_total = 0;
	int          op_tally [4] = '{default: 0};
	int unsigned fill = 0;
	bit          steady = 1'b0;
	int          idle_cycles = 0;

	always #CLK_HALF clk = ~clk;

	dary_max_heap_queue_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	dary_max_heap_queue_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results),
		.results_seen    (results_seen),
		.status_seen     (status_seen)
	);

	// mostly wide random keys, some extremes and a cluster around zero for ties
	function automatic key_t pick_key();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
		if (sel < 3)
			return key_t'(int'($urandom_range(0, 8)) - 4);
		return key_t'($urandom);
	endfunction

	// offer one command beat, with random idle cycles ahead of it outside the steady window
	task automatic send_cmd(input op_t op, input key_t key, input idx_t slot);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= S_DATA_W'({slot, key});
		do @(posedge clk); while (!s_tready);
		sent_total++;
		op_tally[op]++;
		case (op)
			OP_INSERT:  if (fill < CAPACITY) fill++;
			OP_EXTRACT: if (fill > 0) fill--;
			default: ;
		endcase
	endtask

	// stop offering until every predicted result has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
	endtask

	// result side back-pressure, one long hold-off once the run is well underway
	initial begin : result_sink
		int  hold_left;
		bit  held;
		hold_left = 0;
		held      = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && sent_total >= HOLD_AT) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (steady) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_MAX) begin
			$display("%t no beat for %0d cycles", $realtime, WATCHDOG_MAX);
			$display("dary_max_heap_queue_top: mismatch");
			$finish;
		end
	end

	initial begin : command_source
		int unsigned roll;
		bit          filling;
		op_t         op;
		key_t        key;
		idx_t        slot;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty heap: underflow, bad index, no-op
		send_cmd(OP_EXTRACT, KEY_MAX, '0);
		send_cmd(OP_INCREASE, KEY_MAX, '0);
		send_cmd(OP_NOP, '0, '0);
		// key extremes and a tie
		send_cmd(OP_INSERT, KEY_MAX, '0);
		send_cmd(OP_INSERT, KEY_MIN, idx_t'('1));
		send_cmd(OP_INSERT, key_t'(0), '0);
		send_cmd(OP_INSERT, key_t'(-1), '0);
		send_cmd(OP_INSERT, key_t'(5), '0);
		send_cmd(OP_INSERT, key_t'(5), '0);
		// increase: equal key at the root, equal key at a leaf, raise a key to just below the equal root
		send_cmd(OP_INCREASE, KEY_MAX, idx_t'(0));
		send_cmd(OP_INCREASE, KEY_MIN, idx_t'(4));
		send_cmd(OP_INCREASE, KEY_MAX, idx_t'(5));
		// increase at the count and at the last slot: both beyond count
		send_cmd(OP_INCREASE, KEY_MAX, idx_t'(6));
		send_cmd(OP_INCREASE, KEY_MAX, idx_t'(63));
		send_cmd(OP_NOP, key_t'(-1), idx_t'('1));
		send_cmd(OP_INSERT, KEY_MIN, '0);
		// drain completely and one more extract past empty
		repeat (8) send_cmd(OP_EXTRACT, '0, '0);
		wait_drained();

		// random part: alternating fill-biased and drain-biased phases
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2)
				wait_drained();
			steady  = (n >= STEADY_FROM && n < STEADY_TO);
			filling = ((n / PHASE_LEN) % 2 == 0);
			roll    = $urandom_range(0, 99);
			if (roll < (filling ? 75 : 15))
				op = OP_INSERT;
			else if (roll < (filling ? 85 : 80))
				op = OP_EXTRACT;
			else if (roll < 97)
				op = OP_INCREASE;
			else
				op = OP_NOP;
			if (op == OP_INCREASE && $urandom_range(0, 1))
				key = key_t'(32'h7000_0000 + $urandom_range(0, 32'h0fff_ffff));
			else
				key = pick_key();
			if (fill > 0 && $urandom_range(0, 99) < 85)
				slot = idx_t'($urandom_range(0, fill - 1));
			else
				slot = idx_t'($urandom_range(0, CAPACITY - 1));
			send_cmd(op, key, slot);
		end
		steady = 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d commands: %0d insert, %0d extract, %0d increase, %0d no-op",
			sent_total, op_tally[OP_INSERT], op_tally[OP_EXTRACT], op_tally[OP_INCREASE],
			op_tally[OP_NOP]);
		$display("checked %0d result beats, status codes seen (bit per code) %b",
			results_seen, status_seen);
		if (mismatch_count == 0 && pending_results == 0)
			$display("dary_max_heap_queue_top: match");
		else
			$display("dary_max_heap_queue_top: mismatch");
		$finish;
	end

endmodule
